// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds -> consequent holds in the same cycle
`define LKD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// antecedent holds -> consequent holds in the next cycle
`define LKD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/lkd_pkg.sv =====
`timescale 1ns / 1ps

package lkd_pkg;

   localparam logic [2:0] OP_TICK   = 3'd0;
   localparam logic [2:0] OP_WRITE  = 3'd1;
   localparam logic [2:0] OP_BULK   = 3'd2;
   localparam logic [2:0] OP_SINGLE = 3'd3;
   localparam logic [2:0] OP_CMD    = 3'd4;
   localparam logic [2:0] OP_READ   = 3'd5;

   localparam logic [7:0] CMD_AUTO_INC  = 8'h40;
   localparam logic [7:0] CMD_BASE_ADDR = 8'hc0;
   localparam logic [7:0] CMD_FIXED     = 8'h44;
   localparam logic [7:0] CMD_KEY_READ  = 8'h42;

   localparam int SINGLE_FRAME_BYTES = 3;
   localparam int FLASH_BITS         = 8;

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_SEND    = 5'b00010,
      ST_READ    = 5'b00100,
      ST_FINISH  = 5'b01000,
      ST_RESTART = 5'b10000
   } step_type;

   typedef enum logic [1:0] {
      KIND_CMD    = 2'd0,
      KIND_SINGLE = 2'd1,
      KIND_BULK   = 2'd2,
      KIND_READ   = 2'd3
   } kind_type;

   typedef struct packed {
      logic       wr_en;
      logic [3:0] wr_index;
      logic [7:0] wr_data;
      logic       blank_en;
      logic [7:0] blank_mask;
   } store_cmd_type;

   typedef struct packed {
      logic       strobe_res;
      logic       clock_line;
      logic       data_out;
      logic       data_drive;
      logic       busy_res;
      logic [7:0] buttons;
      logic       buttons_valid;
   } rsp_type;

endpackage

// ===== rtl/led_key_display_serial_master.sv =====
`timescale 1ns / 1ps

// Serial master for an LED/key display driver with a strobe, a clock and a data line that
// the master releases while it clocks in key bytes. Every request beat gives exactly one
// response beat carrying the line levels after that beat; a tick beat (op 0) advances the
// line by one half-bit, the other ops load the display buffer or start a transfer and are
// ignored while a transfer runs. The response to a beat sits in the output register from
// the next cycle, so beats can follow back to back; only a response held by a low
// rsp_tready stalls req_tready. The display buffer sits in a RAM with one write port
// and a registered read port whose address follows the next byte count, so each buffer byte
// is ready on the very first cycle it can be shifted out.
module led_key_display_serial_master #(
   parameter int BUFFER_BYTES = 16,
   parameter int READ_BYTES = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [3:0] buffer_index, [11:4] byte_value, [19:12] target_address,
   // [20] flash_phase, [21] read_bit, [23:22] zero
   input  logic [23:0] req_tdata,
   // [2:0] op
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] strobe_res, [1] clock_line, [2] data_out, [3] data_drive,
   // [4] busy_res, [12:5] buttons, [15:13] zero
   output logic [15:0] rsp_tdata,
   // [0] buttons_valid
   output logic        rsp_tuser,
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata
);

   localparam int AW     = $clog2(BUFFER_BYTES);
   localparam int MAXCNT = (BUFFER_BYTES > READ_BYTES) ? BUFFER_BYTES : READ_BYTES;
   localparam int BCW    = $clog2(MAXCNT + 2);

   lkd_pkg::store_cmd_type store_cmd;
   lkd_pkg::rsp_type       result;
   lkd_pkg::rsp_type       rsp_ff;
   logic [AW-1:0]          store_addr;
   logic [7:0]             store_data;
   logic [7:0]             flash_mask_ff;
   logic                   rsp_valid_ff;
   logic                   accept;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         flash_mask_ff <= '0;
      end else if (csr_we) begin
         flash_mask_ff <= csr_wdata;
      end
   end

   lkd_store #(
      .BUFFER_BYTES(BUFFER_BYTES),
      .AW(AW)
   ) u_store (
      .clock(clock),
      .reset(reset),
      .cmd(store_cmd),
      .rd_addr(store_addr),
      .rd_data(store_data)
   );

   lkd_seq #(
      .BUFFER_BYTES(BUFFER_BYTES),
      .READ_BYTES(READ_BYTES),
      .AW(AW),
      .BCW(BCW)
   ) u_seq (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .op(req_tuser),
      .buffer_index(req_tdata[3:0]),
      .byte_value(req_tdata[11:4]),
      .target_address(req_tdata[19:12]),
      .flash_phase(req_tdata[20]),
      .read_bit(req_tdata[21]),
      .flash_mask(flash_mask_ff),
      .store_data(store_data),
      .store_cmd(store_cmd),
      .store_addr(store_addr),
      .result(result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_ff.buttons, rsp_ff.busy_res, rsp_ff.data_drive,
                        rsp_ff.data_out, rsp_ff.clock_line, rsp_ff.strobe_res};
   assign rsp_tuser  = rsp_ff.buttons_valid;

endmodule

// ===== rtl/lkd_store.sv =====
`timescale 1ns / 1ps

module lkd_store #(
   parameter int BUFFER_BYTES = 16,
   parameter int AW = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lkd_pkg::store_cmd_type cmd,
   input  logic [AW-1:0]          rd_addr,
   output logic [7:0]             rd_data
);

   logic [7:0]              mem [BUFFER_BYTES];
   logic [BUFFER_BYTES-1:0] blank_ff;
   logic [BUFFER_BYTES-1:0] blank_in;
   logic [BUFFER_BYTES-1:0] blank_set;
   logic [7:0]              rd_q_ff;
   logic                    blank_q_ff;
   logic [AW+3:0]           wr_wide;
   logic [AW-1:0]           wr_addr;
   logic                    wr_ok;

   assign wr_wide = {{AW{1'b0}}, cmd.wr_index};
   assign wr_addr = wr_wide[AW-1:0];
   assign wr_ok   = cmd.wr_en && (wr_wide < (AW+4)'(BUFFER_BYTES));

   for (genvar j = 0; j < BUFFER_BYTES; j++) begin : g_blank
      if ((j % 2 == 0) && (j < 2 * lkd_pkg::FLASH_BITS)) begin : g_pos
         assign blank_set[j] = cmd.blank_mask[lkd_pkg::FLASH_BITS - 1 - j / 2];
      end else begin : g_none
         assign blank_set[j] = 1'b0;
      end
   end

   always_comb begin
      blank_in = blank_ff;
      if (cmd.blank_en) begin
         blank_in = blank_ff | blank_set;
      end
      if (wr_ok) begin
         blank_in[wr_addr] = 1'b0;
      end
   end

   // a set blank bit reads as zero; reset blanks every entry
   always_ff @(posedge clock) begin
      if (reset) begin
         blank_ff <= '1;
      end else begin
         blank_ff <= blank_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         mem[wr_addr] <= cmd.wr_data;
      end
      rd_q_ff    <= mem[rd_addr];
      blank_q_ff <= blank_ff[rd_addr];
   end

   assign rd_data = blank_q_ff ? 8'h00 : rd_q_ff;

endmodule

// ===== rtl/lkd_seq.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lkd_seq #(
   parameter int BUFFER_BYTES = 16,
   parameter int READ_BYTES = 4,
   parameter int AW = 4,
   parameter int BCW = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [2:0]             op,
   input  logic [3:0]             buffer_index,
   input  logic [7:0]             byte_value,
   input  logic [7:0]             target_address,
   input  logic                   flash_phase,
   input  logic                   read_bit,
   input  logic [7:0]             flash_mask,
   input  logic [7:0]             store_data,
   output lkd_pkg::store_cmd_type store_cmd,
   output logic [AW-1:0]          store_addr,
   output lkd_pkg::rsp_type       result
);

   lkd_pkg::step_type step_ff, step_in;
   lkd_pkg::kind_type kind_ff, kind_in;
   logic           frame_ff, frame_in;
   logic [3:0]     half_ff, half_in;
   logic [BCW-1:0] bc_ff, bc_in;
   logic [7:0]     shift_ff, shift_in;
   logic [7:0]     acc_ff, acc_in;
   logic [7:0]     gather_ff, gather_in;
   logic [7:0]     button_ff, button_in;
   logic [7:0]     value_ff, value_in;
   logic [7:0]     addr_ff, addr_in;
   logic           strobe_ff, strobe_in;
   logic           clk_ff, clk_in;
   logic           data_ff, data_in;
   logic           drive_ff, drive_in;

   logic           valid;
   logic [BCW-1:0] bc_next;
   logic [BCW-1:0] frame_len;
   logic [BCW-1:0] rd_pos;
   logic [7:0]     frame_byte;
   logic [7:0]     cur_byte;
   logic [2:0]     rsh;

   logic           in_frame;
   logic           read_tail;
   logic           read_end;
   logic           between;
   logic           restart_tick;
   logic           resumed;

   always_comb begin
      frame_len = BCW'(1);
      if (kind_ff == lkd_pkg::KIND_SINGLE) begin
         frame_len = BCW'(lkd_pkg::SINGLE_FRAME_BYTES);
      end else if (kind_ff == lkd_pkg::KIND_BULK && frame_ff) begin
         frame_len = BCW'(BUFFER_BYTES + 1);
      end
   end

   always_comb begin
      unique case (kind_ff)
         lkd_pkg::KIND_SINGLE: begin
            if (bc_ff == '0) begin
               frame_byte = lkd_pkg::CMD_FIXED;
            end else if (bc_ff == BCW'(1)) begin
               frame_byte = addr_ff;
            end else begin
               frame_byte = value_ff;
            end
         end
         lkd_pkg::KIND_BULK: begin
            if (!frame_ff) begin
               frame_byte = lkd_pkg::CMD_AUTO_INC;
            end else if (bc_ff == '0) begin
               frame_byte = lkd_pkg::CMD_BASE_ADDR;
            end else begin
               frame_byte = store_data;
            end
         end
         lkd_pkg::KIND_READ: frame_byte = lkd_pkg::CMD_KEY_READ;
         default:            frame_byte = value_ff;
      endcase
   end

   assign cur_byte = (half_ff == 4'd0) ? frame_byte : shift_ff;
   assign bc_next  = bc_ff + BCW'(1);
   assign rsh      = 3'(bc_ff);

   always_comb begin
      step_in   = step_ff;
      kind_in   = kind_ff;
      frame_in  = frame_ff;
      half_in   = half_ff;
      bc_in     = bc_ff;
      shift_in  = shift_ff;
      acc_in    = acc_ff;
      gather_in = gather_ff;
      button_in = button_ff;
      value_in  = value_ff;
      addr_in   = addr_ff;
      strobe_in = strobe_ff;
      clk_in    = clk_ff;
      data_in   = data_ff;
      drive_in  = drive_ff;
      valid     = 1'b0;
      store_cmd = '0;
      store_cmd.wr_index   = buffer_index;
      store_cmd.wr_data    = byte_value;
      store_cmd.blank_mask = flash_mask;

      if (accept) begin
         if (op == lkd_pkg::OP_TICK) begin
            unique case (step_ff)
               lkd_pkg::ST_SEND: begin
                  if (!half_ff[0]) begin
                     shift_in = cur_byte;
                     data_in  = cur_byte[half_ff[3:1]];
                     clk_in   = 1'b0;
                  end else begin
                     clk_in = 1'b1;
                  end
                  half_in = half_ff + 4'd1;
                  if (half_ff == 4'd15) begin
                     bc_in = bc_next;
                     if (bc_next >= frame_len) begin
                        bc_in = '0;
                        if (kind_ff == lkd_pkg::KIND_READ) begin
                           acc_in    = '0;
                           gather_in = '0;
                           step_in   = lkd_pkg::ST_READ;
                        end else begin
                           step_in = lkd_pkg::ST_FINISH;
                        end
                     end
                  end
               end
               lkd_pkg::ST_READ: begin
                  if (!half_ff[0]) begin
                     drive_in = 1'b0;
                     clk_in   = 1'b0;
                  end else begin
                     clk_in = 1'b1;
                     acc_in = {acc_ff[6:0], read_bit};
                  end
                  half_in = half_ff + 4'd1;
                  if (half_ff == 4'd15) begin
                     gather_in = gather_ff | (acc_in >> rsh);
                     bc_in     = bc_next;
                     if (bc_next >= BCW'(READ_BYTES)) begin
                        step_in = lkd_pkg::ST_FINISH;
                     end
                  end
               end
               lkd_pkg::ST_FINISH: begin
                  strobe_in = 1'b1;
                  drive_in  = 1'b1;
                  if (kind_ff == lkd_pkg::KIND_READ) begin
                     button_in = gather_ff;
                     valid     = 1'b1;
                  end
                  if (kind_ff == lkd_pkg::KIND_BULK && !frame_ff) begin
                     frame_in = 1'b1;
                     step_in  = lkd_pkg::ST_RESTART;
                  end else begin
                     step_in = lkd_pkg::ST_IDLE;
                  end
               end
               lkd_pkg::ST_RESTART: begin
                  strobe_in = 1'b0;
                  half_in   = '0;
                  bc_in     = '0;
                  step_in   = lkd_pkg::ST_SEND;
               end
               default: begin
               end
            endcase
         end else if (step_ff == lkd_pkg::ST_IDLE) begin
            unique case (op)
               lkd_pkg::OP_WRITE: store_cmd.wr_en = 1'b1;
               lkd_pkg::OP_BULK: begin
                  store_cmd.blank_en = flash_phase;
                  kind_in = lkd_pkg::KIND_BULK;
               end
               lkd_pkg::OP_SINGLE: begin
                  addr_in  = target_address;
                  value_in = byte_value;
                  kind_in  = lkd_pkg::KIND_SINGLE;
               end
               lkd_pkg::OP_CMD: begin
                  value_in = byte_value;
                  kind_in  = lkd_pkg::KIND_CMD;
               end
               lkd_pkg::OP_READ: kind_in = lkd_pkg::KIND_READ;
               default: begin
               end
            endcase
            if (op == lkd_pkg::OP_BULK || op == lkd_pkg::OP_SINGLE ||
                op == lkd_pkg::OP_CMD || op == lkd_pkg::OP_READ) begin
               frame_in  = 1'b0;
               half_in   = '0;
               bc_in     = '0;
               strobe_in = 1'b0;
               step_in   = lkd_pkg::ST_SEND;
            end
         end
      end
   end

   // read address follows the next byte count: buffer byte k is ready as byte_count reaches k+1
   assign rd_pos     = bc_in - BCW'(1);
   assign store_addr = rd_pos[AW-1:0];

   always_comb begin
      result.strobe_res    = strobe_in;
      result.clock_line    = clk_in;
      result.data_out      = drive_in & data_in;
      result.data_drive    = drive_in;
      result.busy_res      = (step_in != lkd_pkg::ST_IDLE);
      result.buttons       = button_in;
      result.buttons_valid = valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= lkd_pkg::ST_IDLE;
         kind_ff   <= lkd_pkg::KIND_CMD;
         frame_ff  <= 1'b0;
         half_ff   <= '0;
         bc_ff     <= '0;
         shift_ff  <= '0;
         acc_ff    <= '0;
         gather_ff <= '0;
         button_ff <= '0;
         value_ff  <= '0;
         addr_ff   <= '0;
         strobe_ff <= 1'b1;
         clk_ff    <= 1'b1;
         data_ff   <= 1'b0;
         drive_ff  <= 1'b1;
      end else begin
         step_ff   <= step_in;
         kind_ff   <= kind_in;
         frame_ff  <= frame_in;
         half_ff   <= half_in;
         bc_ff     <= bc_in;
         shift_ff  <= shift_in;
         acc_ff    <= acc_in;
         gather_ff <= gather_in;
         button_ff <= button_in;
         value_ff  <= value_in;
         addr_ff   <= addr_in;
         strobe_ff <= strobe_in;
         clk_ff    <= clk_in;
         data_ff   <= data_in;
         drive_ff  <= drive_in;
      end
   end

   assign in_frame     = (step_ff == lkd_pkg::ST_SEND) || (step_ff == lkd_pkg::ST_READ) ||
                         (step_ff == lkd_pkg::ST_FINISH);
   assign read_tail    = (step_ff == lkd_pkg::ST_READ) || (step_ff == lkd_pkg::ST_FINISH);
   assign read_end     = (step_ff == lkd_pkg::ST_FINISH) && (kind_ff == lkd_pkg::KIND_READ);
   assign between      = (step_ff == lkd_pkg::ST_IDLE) || (step_ff == lkd_pkg::ST_FINISH) ||
                         (step_ff == lkd_pkg::ST_RESTART);
   assign restart_tick = accept && (op == lkd_pkg::OP_TICK) && (step_ff == lkd_pkg::ST_RESTART);
   assign resumed      = (step_ff == lkd_pkg::ST_SEND) && (bc_ff == '0);

   `LKD_ASSERT_SAME(a_strobe_low_in_frame, clock, reset, in_frame, !strobe_ff)
   `LKD_ASSERT_SAME(a_release_only_reading, clock, reset, !drive_ff, read_tail)
   `LKD_ASSERT_SAME(a_valid_at_read_end, clock, reset, valid, read_end)
   `LKD_ASSERT_SAME(a_half_zero_between, clock, reset, between, half_ff == 4'd0)
   `LKD_ASSERT_NEXT(a_restart_resumes, clock, reset, restart_tick, resumed)

endmodule

// ===== tb/led_key_display_serial_master_tb.sv =====
`timescale 1ns / 1ps

module led_key_display_serial_master_tb;

   localparam int BUFFER_BYTES = 16;
   localparam int READ_BYTES = 4;
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;
   localparam int BITS_LOW = 0;
   localparam int BITS_HIGH = 1;
   localparam int BITS_RANDOM = 2;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic [2:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_we;
   logic [7:0]  csr_wdata;

   led_key_display_serial_master #(
      .BUFFER_BYTES(BUFFER_BYTES),
      .READ_BYTES(READ_BYTES)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   // line model
   logic [7:0]        disp_mem [BUFFER_BYTES];
   logic [7:0]        flash_mask_q;
   lkd_pkg::step_type seq_step;
   lkd_pkg::kind_type cur_kind;
   logic              second_frame;
   int                half_cnt;
   int                byte_cnt;
   logic [7:0] shift_q, acc_q, gather_q, btn_q, req_val_q, req_addr_q;
   logic       strobe_q, clk_q, data_q, drive_q;

   lkd_pkg::rsp_type expected_lines [$];
   bit  idle_on;
   int  stall_left;
   int  mismatches;
   int  responses_checked;
   int  active_beats;
   int  reads_started;
   int  bulks_started;
   int  config_writes;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic void clear_line_model();
      for (int i = 0; i < BUFFER_BYTES; i++) disp_mem[i] = 8'h00;
      flash_mask_q = 8'h00;
      seq_step = lkd_pkg::ST_IDLE;
      cur_kind = lkd_pkg::KIND_CMD;
      second_frame = 1'b0;
      half_cnt = 0;
      byte_cnt = 0;
      shift_q = 8'h00;
      acc_q = 8'h00;
      gather_q = 8'h00;
      btn_q = 8'h00;
      req_val_q = 8'h00;
      req_addr_q = 8'h00;
      strobe_q = 1'b1;
      clk_q = 1'b1;
      data_q = 1'b0;
      drive_q = 1'b1;
   endfunction

   function automatic void open_frame(input lkd_pkg::kind_type kind);
      cur_kind = kind;
      second_frame = 1'b0;
      half_cnt = 0;
      byte_cnt = 0;
      strobe_q = 1'b0;
      seq_step = lkd_pkg::ST_SEND;
   endfunction

   function automatic lkd_pkg::rsp_type predict_line_levels(input logic [2:0] op,
         input logic [3:0] idx, input logic [7:0] val, input logic [7:0] addr,
         input logic fphase, input logic rbit);
      lkd_pkg::rsp_type lv;
      logic    done;
      int      frame_len;
      int      pos;
      done = 1'b0;
      if (op == lkd_pkg::OP_TICK) begin
         case (seq_step)
            lkd_pkg::ST_SEND: begin
               if (!half_cnt[0]) begin
                  if (half_cnt == 0) begin
                     case (cur_kind)
                        lkd_pkg::KIND_SINGLE:
                           shift_q = (byte_cnt == 0) ? lkd_pkg::CMD_FIXED :
                                     ((byte_cnt == 1) ? req_addr_q : req_val_q);
                        lkd_pkg::KIND_BULK:
                           shift_q = !second_frame ? lkd_pkg::CMD_AUTO_INC :
                                     ((byte_cnt == 0) ? lkd_pkg::CMD_BASE_ADDR :
                                      disp_mem[byte_cnt - 1]);
                        lkd_pkg::KIND_READ: shift_q = lkd_pkg::CMD_KEY_READ;
                        default: shift_q = req_val_q;
                     endcase
                  end
                  data_q = shift_q[half_cnt >> 1];
                  clk_q = 1'b0;
               end else begin
                  clk_q = 1'b1;
               end
               half_cnt++;
               if (cur_kind == lkd_pkg::KIND_SINGLE) frame_len = lkd_pkg::SINGLE_FRAME_BYTES;
               else if (cur_kind == lkd_pkg::KIND_BULK && second_frame)
                  frame_len = 1 + BUFFER_BYTES;
               else frame_len = 1;
               if (half_cnt >= 16) begin
                  half_cnt = 0;
                  byte_cnt++;
                  if (byte_cnt >= frame_len) begin
                     byte_cnt = 0;
                     if (cur_kind == lkd_pkg::KIND_READ) begin
                        acc_q = 8'h00;
                        gather_q = 8'h00;
                        seq_step = lkd_pkg::ST_READ;
                     end else begin
                        seq_step = lkd_pkg::ST_FINISH;
                     end
                  end
               end
            end
            lkd_pkg::ST_READ: begin
               if (!half_cnt[0]) begin
                  drive_q = 1'b0;
                  clk_q = 1'b0;
               end else begin
                  clk_q = 1'b1;
                  acc_q = {acc_q[6:0], rbit};
               end
               half_cnt++;
               if (half_cnt >= 16) begin
                  half_cnt = 0;
                  gather_q = gather_q | (acc_q >> (byte_cnt & 7));
                  byte_cnt++;
                  if (byte_cnt >= READ_BYTES) seq_step = lkd_pkg::ST_FINISH;
               end
            end
            lkd_pkg::ST_FINISH: begin
               strobe_q = 1'b1;
               drive_q = 1'b1;
               if (cur_kind == lkd_pkg::KIND_READ) begin
                  btn_q = gather_q;
                  done = 1'b1;
               end
               if (cur_kind == lkd_pkg::KIND_BULK && !second_frame) begin
                  second_frame = 1'b1;
                  seq_step = lkd_pkg::ST_RESTART;
               end else begin
                  seq_step = lkd_pkg::ST_IDLE;
               end
            end
            lkd_pkg::ST_RESTART: begin
               strobe_q = 1'b0;
               half_cnt = 0;
               byte_cnt = 0;
               seq_step = lkd_pkg::ST_SEND;
            end
            default: ;
         endcase
      end else if (seq_step == lkd_pkg::ST_IDLE) begin
         case (op)
            lkd_pkg::OP_WRITE: if (idx < BUFFER_BYTES) disp_mem[idx] = val;
            lkd_pkg::OP_BULK: begin
               if (fphase) begin
                  for (int i = 0; i < lkd_pkg::FLASH_BITS; i++) begin
                     pos = 2 * (lkd_pkg::FLASH_BITS - 1 - i);
                     if (flash_mask_q[i] && pos < BUFFER_BYTES) disp_mem[pos] = 8'h00;
                  end
               end
               open_frame(lkd_pkg::KIND_BULK);
            end
            lkd_pkg::OP_SINGLE: begin
               req_addr_q = addr;
               req_val_q = val;
               open_frame(lkd_pkg::KIND_SINGLE);
            end
            lkd_pkg::OP_CMD: begin
               req_val_q = val;
               open_frame(lkd_pkg::KIND_CMD);
            end
            lkd_pkg::OP_READ: open_frame(lkd_pkg::KIND_READ);
            default: ;
         endcase
      end
      lv.strobe_res = strobe_q;
      lv.clock_line = clk_q;
      lv.data_out = drive_q & data_q;
      lv.data_drive = drive_q;
      lv.busy_res = (seq_step != lkd_pkg::ST_IDLE);
      lv.buttons = btn_q;
      lv.buttons_valid = done;
      return lv;
   endfunction

   // response side: random stall bursts
   initial begin
      rsp_tready = 1'b1;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (idle_on && stall_left == 0 && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 16);
         if (idle_on && stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            stall_left = 0;
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : check_rsp
      lkd_pkg::rsp_type got;
      lkd_pkg::rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.strobe_res = rsp_tdata[0];
         got.clock_line = rsp_tdata[1];
         got.data_out = rsp_tdata[2];
         got.data_drive = rsp_tdata[3];
         got.busy_res = rsp_tdata[4];
         got.buttons = rsp_tdata[12:5];
         got.buttons_valid = rsp_tuser;
         if (expected_lines.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected response beat tdata=%h tuser=%b",
                        $time, rsp_tdata, rsp_tuser);
         end else begin
            want = expected_lines.pop_front();
            responses_checked++;
            if (got.strobe_res !== want.strobe_res || got.clock_line !== want.clock_line ||
                got.data_out !== want.data_out || got.data_drive !== want.data_drive ||
                got.busy_res !== want.busy_res || got.buttons !== want.buttons ||
                got.buttons_valid !== want.buttons_valid) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t: mismatch exp stb=%b clk=%b dat=%b drv=%b busy=%b btn=%h vld=%b",
                           $time, want.strobe_res, want.clock_line, want.data_out,
                           want.data_drive, want.busy_res, want.buttons, want.buttons_valid);
                  $display("%0t:          got stb=%b clk=%b dat=%b drv=%b busy=%b btn=%h vld=%b",
                           $time, got.strobe_res, got.clock_line, got.data_out,
                           got.data_drive, got.busy_res, got.buttons, got.buttons_valid);
               end
            end
         end
      end
   end

   task automatic send_item(input logic [2:0] op, input logic [3:0] idx, input logic [7:0] val,
         input logic [7:0] addr, input logic fphase, input logic rbit);
      logic was_busy;
      @(negedge clock);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {2'b00, rbit, fphase, addr, val, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      was_busy = (seq_step != lkd_pkg::ST_IDLE);
      expected_lines.push_back(predict_line_levels(op, idx, val, addr, fphase, rbit));
      if ((op == lkd_pkg::OP_TICK && was_busy) ||
          (op >= lkd_pkg::OP_WRITE && op <= lkd_pkg::OP_READ && !was_busy))
         active_beats++;
      if (!was_busy && op == lkd_pkg::OP_READ) reads_started++;
      if (!was_busy && op == lkd_pkg::OP_BULK) bulks_started++;
   endtask

   // one beat of the given op with random operands
   task automatic send_random(input logic [2:0] op);
      send_item(op, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
   endtask

   task automatic send_tick(input int bit_mode);
      logic rb;
      rb = (bit_mode == BITS_RANDOM) ? 1'($urandom_range(0, 1)) : (bit_mode == BITS_HIGH);
      send_item(lkd_pkg::OP_TICK, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), rb);
   endtask

   // tick until the line model is idle; optionally slip in requests that must be ignored
   task automatic run_transfer(input int bit_mode, input bit inject);
      while (seq_step != lkd_pkg::ST_IDLE) begin
         if (inject && $urandom_range(0, 15) == 0)
            send_random(3'($urandom_range(lkd_pkg::OP_WRITE, lkd_pkg::OP_READ)));
         else
            send_tick(bit_mode);
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_lines.size() != 0) @(negedge clock);
   endtask

   task automatic write_flash_mask(input logic [7:0] mask);
      wait_drained();
      csr_we <= 1'b1;
      csr_wdata <= mask;
      @(negedge clock);
      csr_we <= 1'b0;
      flash_mask_q = mask;
      config_writes++;
   endtask

   task automatic test_idle_and_unused();
      send_item(lkd_pkg::OP_TICK, 4'h0, 8'h00, 8'h00, 1'b0, 1'b0);
      send_item(lkd_pkg::OP_TICK, 4'hf, 8'hff, 8'hff, 1'b1, 1'b1);
      send_item(OP_SPARE_6, 4'hf, 8'hff, 8'hff, 1'b1, 1'b1);
      send_item(OP_SPARE_7, 4'h0, 8'h00, 8'h00, 1'b0, 1'b0);
      send_item(OP_SPARE_7, 4'hf, 8'hff, 8'hff, 1'b1, 1'b1);
   endtask

   task automatic test_lone_command();
      send_item(lkd_pkg::OP_CMD, 4'h0, 8'h00, 8'h00, 1'b0, 1'b0);
      run_transfer(BITS_RANDOM, 1'b0);
      send_item(lkd_pkg::OP_CMD, 4'hf, 8'hff, 8'hff, 1'b1, 1'b1);
      run_transfer(BITS_RANDOM, 1'b0);
   endtask

   task automatic test_single_write();
      send_item(lkd_pkg::OP_SINGLE, 4'h0, 8'h00, 8'hff, 1'b0, 1'b0);
      run_transfer(BITS_RANDOM, 1'b0);
      send_item(lkd_pkg::OP_SINGLE, 4'hf, 8'hff, 8'h00, 1'b1, 1'b1);
      run_transfer(BITS_RANDOM, 1'b0);
   endtask

   task automatic test_busy_requests();
      send_item(lkd_pkg::OP_CMD, 4'h3, 8'ha5, 8'h5a, 1'b0, 1'b0);
      for (int op = lkd_pkg::OP_WRITE; op <= lkd_pkg::OP_READ; op++) begin
         repeat (3) send_tick(BITS_RANDOM);
         send_item(3'(op), 4'hf, 8'hff, 8'hff, 1'b1, 1'b1);
      end
      run_transfer(BITS_RANDOM, 1'b0);
   endtask

   task automatic test_button_read();
      send_item(lkd_pkg::OP_READ, 4'h0, 8'h00, 8'h00, 1'b0, 1'b1);
      run_transfer(BITS_HIGH, 1'b0);
      wait_drained();
      send_item(lkd_pkg::OP_READ, 4'hf, 8'hff, 8'hff, 1'b1, 1'b0);
      run_transfer(BITS_LOW, 1'b0);
      send_item(lkd_pkg::OP_READ, 4'h5, 8'h3c, 8'hc3, 1'b0, 1'b1);
      run_transfer(BITS_RANDOM, 1'b0);
   endtask

   task automatic test_flash_bulk();
      for (int i = 0; i < BUFFER_BYTES; i++)
         send_item(lkd_pkg::OP_WRITE, 4'(i),
                   (i == 0) ? 8'hff : ((i == BUFFER_BYTES - 1) ? 8'h00 :
                                       8'($urandom_range(1, 255))),
                   8'($urandom_range(0, 255)), 1'b0, 1'b0);
      write_flash_mask(8'hff);
      send_item(lkd_pkg::OP_BULK, 4'h0, 8'h00, 8'h00, 1'b1, 1'b0);
      run_transfer(BITS_RANDOM, 1'b0);
   endtask

   task automatic test_random_traffic(input int target, input bit allow_idle);
      int stop_at;
      int pick;
      stop_at = active_beats + target;
      while (active_beats < stop_at) begin
         idle_on = allow_idle && ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            write_flash_mask(($urandom_range(0, 3) == 0) ? 8'hff : 8'($urandom_range(0, 255)));
         end else if (pick < 33) begin
            send_random(lkd_pkg::OP_WRITE);
         end else if (pick < 93) begin
            case ($urandom_range(0, 9))
               0, 1, 2: send_random(lkd_pkg::OP_CMD);
               3, 4, 5: send_random(lkd_pkg::OP_SINGLE);
               6, 7, 8: send_random(lkd_pkg::OP_READ);
               default: send_random(lkd_pkg::OP_BULK);
            endcase
            run_transfer(BITS_RANDOM, 1'b1);
         end else begin
            send_random($urandom_range(0, 1) ? OP_SPARE_6 :
                        ($urandom_range(0, 1) ? OP_SPARE_7 : lkd_pkg::OP_TICK));
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = lkd_pkg::OP_TICK;
      csr_we = 1'b0;
      csr_wdata = 8'h00;
      idle_on = 1'b1;
      mismatches = 0;
      responses_checked = 0;
      active_beats = 0;
      reads_started = 0;
      bulks_started = 0;
      config_writes = 0;
      clear_line_model();
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      test_idle_and_unused();
      test_lone_command();
      test_single_write();
      test_busy_requests();
      test_button_read();
      test_flash_bulk();
      test_random_traffic(250, 1'b1);
      test_random_traffic(50, 1'b0);

      wait_drained();
      repeat (20) @(negedge clock);
      $display("Covered %0d working beats, %0d response beats checked, %0d mask writes",
               active_beats, responses_checked, config_writes);
      $display("Button reads: %0d, bulk updates: %0d, mismatches: %0d",
               reads_started, bulks_started, mismatches);
      if (mismatches == 0 && expected_lines.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/lkd_pkg.sv
rtl/lkd_store.sv
rtl/lkd_seq.sv
rtl/led_key_display_serial_master.sv
tb/led_key_display_serial_master_tb.sv
